[sv/assert_macros.svh]
// Assertion macros used by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check, but also evaluated while reset is asserted.
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/dq_pkg.sv]
// Types and constants of the bounded deque with search.
`default_nettype none

package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int VAL_W  = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;
  localparam int ECNT_W = 5;
  localparam int OUT_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_LOAD,
    CM_LEFT,
    CM_RIGHT
  } cell_mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_SRCH
  } state_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       cmp_en;
    logic       occupied;
  } cell_ctl_t;

endpackage

`default_nettype wire

[sv/dq_cell.sv]
// One slot of the deque: data register, neighbor shift and match flag.
`default_nettype none

module dq_cell
  import dq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire cell_ctl_t        ctl_i,
  input  wire logic [VAL_W-1:0] key_i,
  input  wire logic [VAL_W-1:0] left_i,
  input  wire logic [VAL_W-1:0] right_i,
  output logic      [VAL_W-1:0] data_o,
  output logic                  match_o
);

  logic [VAL_W-1:0] data_q, data_d;
  logic             match_q, match_d;

  always_comb begin
    unique case (ctl_i.mode)
      CM_LOAD:  data_d = key_i;
      CM_LEFT:  data_d = left_i;
      CM_RIGHT: data_d = right_i;
      default:  data_d = data_q;
    endcase
    match_d = ctl_i.cmp_en ? (ctl_i.occupied && (data_q == key_i)) : match_q;
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

[sv/bounded_deque_with_search.sv]
// Bounded deque with search: a row of shifting cells plus control.
//
// Requests enter on the s_axis channel: tuser carries the operation
// (push front, push back, pop front, pop back, search), tdata the 32-bit
// signed value. Every request gives exactly one result beat on m_axis:
// tuser is the status, tdata packs found, position and entry count.
// Entries sit in a row of cells, front in cell 0. Push front and pop front
// shift the whole row by one cell; push back loads the cell at the count;
// pop back only lowers the count.
// Pushes, pops and unused codes register their result at the accept edge,
// and a new request can follow in the next cycle if the receiver is ready.
// In a search, every cell compares its entry with the key at the accept
// edge, then the registered match flags are priority-encoded into the
// output register; no new request is taken meanwhile.
// After reset the deque is empty and no result is pending.
// If the receiver stalls, the result waits in the output register; a new
// request is taken only once that register is free or drains that cycle.
`default_nettype none
`include "assert_macros.svh"

module bounded_deque_with_search
  import dq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [VAL_W-1:0]  s_axis_tdata,  // [31:0] value
  input  wire logic [OP_W-1:0]   s_axis_tuser,  // [2:0] operation
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [OUT_W-1:0]  m_axis_tdata,  // [0] found, [4:1] position,
                                                // [9:5] entry_count, rest 0
  output logic      [STAT_W-1:0] m_axis_tuser   // [1:0] status
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              m_valid_q, m_valid_d;
  logic              res_load;
  stat_e             res_stat_d, res_stat_q;
  logic              res_found_d, res_found_q;
  logic [POS_W-1:0]  res_pos_d, res_pos_q;
  logic [ECNT_W-1:0] res_cnt_d, res_cnt_q;

  cell_ctl_t         ctl [DEPTH];
  logic [VAL_W-1:0]  cell_data [DEPTH];
  logic [DEPTH-1:0]  match;
  logic              accept;
  logic              full, empty;
  op_e               op;
  logic [IDX_W-1:0]  first_idx;

  assign op     = op_e'(s_axis_tuser);
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;

  // Lowest matching cell is the one nearest the front.
  always_comb begin
    first_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_load    = 1'b0;
    res_stat_d  = STAT_DONE;
    res_found_d = 1'b0;
    res_pos_d   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].mode     = CM_HOLD;
      ctl[i].cmp_en   = 1'b0;
      ctl[i].occupied = (CNT_W'(i) < count_q);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (op)
            OP_PUSH_FRONT: begin
              if (full) begin
                res_stat_d = STAT_PUSH_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) ctl[i].mode = CM_LEFT;
                count_d = count_q + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                res_stat_d = STAT_PUSH_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (CNT_W'(i) == count_q) ctl[i].mode = CM_LOAD;
                end
                count_d = count_q + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                res_stat_d = STAT_POP_EMPTY;
              end else begin
                for (int i = 0; i < DEPTH; i++) ctl[i].mode = CM_RIGHT;
                count_d = count_q - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                res_stat_d = STAT_POP_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            OP_SEARCH: begin
              for (int i = 0; i < DEPTH; i++) ctl[i].cmp_en = 1'b1;
              res_load = 1'b0;
              state_d  = ST_SRCH;
            end
            default: ;
          endcase
        end
      end
      ST_SRCH: begin
        res_load    = 1'b1;
        res_found_d = |match;
        res_pos_d   = (|match) ? POS_W'(first_idx) : '0;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    res_cnt_d = ECNT_W'(count_d);
    if (res_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_stat_q  <= res_stat_d;
      res_found_q <= res_found_d;
      res_pos_q   <= res_pos_d;
      res_cnt_q   <= res_cnt_d;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] left, right;
    if (g == 0) begin : g_head
      assign left = s_axis_tdata;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    dq_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[g]),
      .key_i   (s_axis_tdata),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .match_o (match[g])
    );
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = res_stat_q;
  assign m_axis_tdata  = {{(OUT_W - 1 - POS_W - ECNT_W){1'b0}},
                          res_cnt_q, res_pos_q, res_found_q};

  `DQ_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
  `DQ_ASSERT(a_search_stage, accept && op == OP_SEARCH |=> state_q == ST_SRCH && !s_axis_tready, "search did not enter match stage")
  `DQ_ASSERT(a_no_overwrite, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "request taken while result blocked")
  `DQ_ASSERT(a_push_count, accept && op == OP_PUSH_BACK && !full |=> count_q == $past(count_q) + 1'b1, "push back did not grow count")

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the bounded deque with search over its stream ports.
module testbench
  import dq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1725;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  // Traffic shaping for the random part.
  typedef enum int {BIAS_GROW, BIAS_SHRINK, BIAS_MIX} bias_e;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    int               phase;
  } request_t;

  typedef struct {
    stat_e             status;
    logic              found;
    logic [POS_W-1:0]  position;
    logic [ECNT_W-1:0] entry_count;
  } deque_result_t;

  // Idle and stall rates in percent per phase.
  int send_idle_pct[4]  = '{0, 63, 0, 11};
  int recv_stall_pct[4] = '{0, 0, 63, 11};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [VAL_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0] m_axis_tuser;

  request_t pending_reqs[$];
  deque_result_t expected_results[$];
  int active_phase = 0;
  int error_count = 0;
  int cycle_count = 0;

  // Shadow deque state.
  logic [VAL_W-1:0] shadow_mem[DEPTH];
  logic [IDX_W-1:0] shadow_front = '0;
  logic [CNT_W-1:0] shadow_count = '0;

  int ops_seen[8] = '{default: 0};
  int full_drops = 0;
  int empty_pops = 0;
  int search_hits = 0;
  int results_checked = 0;
  int peak_count = 0;

  bounded_deque_with_search u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] value
    .s_axis_tuser  (s_axis_tuser),   // [2:0] operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] found, [4:1] position, [9:5] entry_count
    .m_axis_tuser  (m_axis_tuser)    // [1:0] status
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one accepted request to the shadow deque and queue its result.
  task automatic apply_deque_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
    deque_result_t r;
    logic [IDX_W-1:0] slot;
    r.status = STAT_DONE;
    r.found = 1'b0;
    r.position = '0;
    ops_seen[op]++;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          r.status = STAT_PUSH_FULL;
          full_drops++;
        end else if (op == OP_PUSH_FRONT) begin
          shadow_front = shadow_front - 1'b1;
          shadow_mem[shadow_front] = val;
          shadow_count++;
        end else begin
          slot = shadow_front + shadow_count[IDX_W-1:0];
          shadow_mem[slot] = val;
          shadow_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = STAT_POP_EMPTY;
          empty_pops++;
        end else begin
          if (op == OP_POP_FRONT) shadow_front = shadow_front + 1'b1;
          shadow_count--;
        end
      end
      OP_SEARCH: begin
        for (int k = 0; k < shadow_count; k++) begin
          slot = shadow_front + k[IDX_W-1:0];
          if (shadow_mem[slot] == val) begin
            r.found = 1'b1;
            r.position = k[POS_W-1:0];
            search_hits++;
            break;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_count;
    if (shadow_count > peak_count) peak_count = shadow_count;
    expected_results.push_back(r);
  endtask

  // Driver: offers queued requests, predicts on every accepted beat.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t req;
    logic slot_free;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_deque_op(s_axis_tuser, s_axis_tdata);
      slot_free = !s_axis_tvalid || s_axis_tready;
      if (slot_free) begin
        if (pending_reqs.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct[pending_reqs[0].phase]) begin
          req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= req.op;
          s_axis_tdata <= req.value;
          active_phase <= req.phase;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls at random and checks every result beat.
  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t exp_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d tdata 0x%04h",
                 m_axis_tuser, m_axis_tdata);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          results_checked++;
          if (m_axis_tuser !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
            error_count++;
          end
          if (m_axis_tdata[0] !== exp_r.found) begin
            $error("found: expected %0d, got %0d", exp_r.found, m_axis_tdata[0]);
            error_count++;
          end
          if (m_axis_tdata[4:1] !== exp_r.position) begin
            $error("position: expected %0d, got %0d", exp_r.position, m_axis_tdata[4:1]);
            error_count++;
          end
          if (m_axis_tdata[9:5] !== exp_r.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   exp_r.entry_count, m_axis_tdata[9:5]);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct[active_phase]);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_req(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                         input int phase);
    request_t req;
    req.op = op;
    req.value = val;
    req.phase = phase;
    pending_reqs.push_back(req);
  endtask

  function automatic logic [OP_W-1:0] pick_op(input bias_e bias);
    int roll;
    int push_pct;
    roll = $urandom_range(0, 99);
    push_pct = (bias == BIAS_GROW) ? 60 : (bias == BIAS_SHRINK) ? 20 : 40;
    if (roll >= 97) return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (roll < push_pct) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (roll < 80) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    return OP_SEARCH;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [VAL_W-1:0] recent_vals[$];
    logic [OP_W-1:0] op;
    logic [VAL_W-1:0] val;
    bias_e bias;
    int seg_left;
    int total_reqs;

    // Directed: empty-queue corner cases first.
    add_req(OP_SEARCH, 32'h0, 0);
    add_req(OP_POP_FRONT, 32'hFFFF_FFFF, 0);
    add_req(OP_POP_BACK, 32'h0, 0);
    add_req(OP_UNUSED_HI, 32'h1234_5678, 0);
    add_req(OP_PUSH_FRONT, 32'h8000_0000, 0);
    add_req(OP_PUSH_BACK, 32'h7FFF_FFFF, 0);
    add_req(OP_PUSH_FRONT, 32'hFFFF_FFFF, 0);
    add_req(OP_PUSH_BACK, 32'h0, 0);
    add_req(OP_SEARCH, 32'h7FFF_FFFF, 0);
    add_req(OP_SEARCH, 32'h5A5A_5A5A, 0);
    // duplicate at the back; search must report the copy nearest the front
    add_req(OP_PUSH_BACK, 32'hFFFF_FFFF, 0);
    add_req(OP_SEARCH, 32'hFFFF_FFFF, 0);
    for (int k = 0; k < DEPTH - 5; k++)
      add_req((k % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'h100 + k, 0);
    add_req(OP_PUSH_FRONT, 32'h55AA_55AA, 0);
    add_req(OP_PUSH_BACK, 32'hAA55_AA55, 0);
    add_req(OP_SEARCH, 32'h0, 0);

    // Random: segments that lean toward filling or draining the deque.
    seg_left = 0;
    bias = BIAS_MIX;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(15, 40);
        bias = bias_e'($urandom_range(0, 2));
      end
      seg_left--;
      op = pick_op(bias);
      val = pick_value();
      if (op == OP_SEARCH && recent_vals.size() != 0 && $urandom_range(0, 99) < 60)
        val = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
        recent_vals.push_back(val);
        if (recent_vals.size() > 12) void'(recent_vals.pop_front());
      end
      add_req(op, val, (i * 4) / N_RANDOM);
    end
    total_reqs = pending_reqs.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every request gives one result beat.
    while (results_checked < total_reqs)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end

    $display("Checked %0d results: push front %0d, push back %0d, pop front %0d, pop back %0d,",
             results_checked, ops_seen[OP_PUSH_FRONT], ops_seen[OP_PUSH_BACK],
             ops_seen[OP_POP_FRONT], ops_seen[OP_POP_BACK]);
    $display("search %0d (%0d hits), dropped pushes %0d, empty pops %0d, peak depth %0d",
             ops_seen[OP_SEARCH], search_hits, full_drops, empty_pops, peak_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
